[hdl/binary_to_decimal_ascii_unit_defines.svh]
// ----------------------------------------------------------------------------
// Binary to decimal ASCII unit: assertion macros
// Concurrent checks clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BDA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define BDA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define BDA_ASSERT_IMP(lbl, ante, cons)
`define BDA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[hdl/bda_pkg.sv]
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Widths, pipeline sizing and the shift-add-3 step used by the converter.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int NumW      = 32;
    localparam int NumDigits = 10;
    localparam int BcdW      = 4 * NumDigits;
    localparam int WorkW     = BcdW + NumW;
    localparam int ItersPerStg = 4;
    localparam int NumStg    = NumW / ItersPerStg;
    localparam int CharW     = 6;
    localparam int CntW      = 4;

    // Upper two bits of ASCII '0' .. '9'; the low nibble is the digit itself.
    localparam logic [1:0] AsciiDigitHi = 2'b11;

    typedef logic [WorkW-1:0] work_t;
    typedef logic [BcdW-1:0]  bcd_t;
    typedef logic [CntW-1:0]  cnt_t;

    // Four double-dabble iterations: correct each BCD nibble, then shift left.
    function automatic work_t dabble_step(input work_t st);
        work_t w;
        w = st;
        for (int it = 0; it < ItersPerStg; it++) begin
            for (int d = 0; d < NumDigits; d++) begin
                if (w[NumW + 4*d +: 4] >= 4'd5) begin
                    w[NumW + 4*d +: 4] = w[NumW + 4*d +: 4] + 4'd3;
                end
            end
            w = {w[WorkW-2:0], 1'b0};
        end
        return w;
    endfunction

endpackage

[hdl/binary_to_decimal_ascii_unit.sv]
// ----------------------------------------------------------------------------
// Binary to decimal ASCII unit
// Converts unsigned 32-bit values to decimal ASCII digits, MSD first.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_number take one request per value. m_valid/m_ready
//   with m_digit_char and m_last_digit return one digit per beat, most
//   significant first, leading zeros dropped; zero gives a single '0'.
//   m_last_digit marks the final digit of each value.
// Path: a taken request passes through eight shift-add-3 stages of four
//   iterations each, one digit alignment stage, then the output register,
//   before the first digit of its value appears.
// Throughput: the pipeline takes a request every cycle while it has room;
//   the digit emitter sends one digit per cycle while m_ready is high; a
//   value has 1 to 10 digits, and values follow back to back.
// Reset: aresetn low clears all valid bits; pending values are dropped.
// Stall: while m_ready is low the current digit holds, the stages fill up,
//   and s_ready falls once every stage holds a value.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_unit_defines.svh"

module binary_to_decimal_ascii_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bda_pkg::NumW-1:0]      s_number,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bda_pkg::CharW-1:0]     m_digit_char,
    output logic                          m_last_digit
);

    // Conversion stages
    bda_pkg::work_t               stg_data_reg [bda_pkg::NumStg];
    logic [bda_pkg::NumStg-1:0]   stg_valid_reg;
    logic [bda_pkg::NumStg:0]     stg_open;

    // Alignment stage
    logic                         al_valid_reg;
    bda_pkg::bcd_t                al_bcd_reg;
    bda_pkg::cnt_t                al_ndig_reg;
    logic                         al_take;
    bda_pkg::cnt_t                al_ndig_next;
    bda_pkg::bcd_t                al_bcd_next;
    logic [5:0]                   al_shamt;
    bda_pkg::bcd_t                stg_bcd;

    // Digit emitter
    logic                         em_valid_reg;
    bda_pkg::bcd_t                em_bcd_reg;
    bda_pkg::cnt_t                em_cnt_reg;
    logic                         em_load;
    logic                         em_fire;

    assign em_fire = em_valid_reg && m_ready;
    assign em_load = al_valid_reg &&
                     (!em_valid_reg || (m_ready && em_cnt_reg == bda_pkg::cnt_t'(1)));
    assign al_take = !al_valid_reg || em_load;

    // A stage may take new data when empty or when its contents move on.
    always_comb begin
        stg_open[bda_pkg::NumStg] = al_take;
        for (int k = bda_pkg::NumStg - 1; k >= 0; k--) begin
            stg_open[k] = !stg_valid_reg[k] || stg_open[k+1];
        end
    end

    assign s_ready = stg_open[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= '0;
        end else begin
            if (stg_open[0]) begin
                stg_valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < bda_pkg::NumStg; k++) begin
                if (stg_open[k]) begin
                    stg_valid_reg[k] <= stg_valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_open[0]) begin
            stg_data_reg[0] <= bda_pkg::dabble_step({{bda_pkg::BcdW{1'b0}}, s_number});
        end
        for (int k = 1; k < bda_pkg::NumStg; k++) begin
            if (stg_open[k]) begin
                stg_data_reg[k] <= bda_pkg::dabble_step(stg_data_reg[k-1]);
            end
        end
    end

    // Count significant digits and move the leading one to the top nibble.
    assign stg_bcd = stg_data_reg[bda_pkg::NumStg-1][bda_pkg::WorkW-1:bda_pkg::NumW];

    always_comb begin
        al_ndig_next = bda_pkg::cnt_t'(1);
        for (int d = 0; d < bda_pkg::NumDigits; d++) begin
            if (stg_bcd[4*d +: 4] != 4'd0) begin
                al_ndig_next = bda_pkg::cnt_t'(d + 1);
            end
        end
        al_shamt    = {bda_pkg::cnt_t'(bda_pkg::NumDigits) - al_ndig_next, 2'b00};
        al_bcd_next = stg_bcd << al_shamt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            al_valid_reg <= 1'b0;
        end else if (al_take) begin
            al_valid_reg <= stg_valid_reg[bda_pkg::NumStg-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (al_take) begin
            al_bcd_reg  <= al_bcd_next;
            al_ndig_reg <= al_ndig_next;
        end
    end

    // Emit the top nibble, then shift the next digit up.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_valid_reg <= 1'b0;
        end else if (em_load) begin
            em_valid_reg <= 1'b1;
        end else if (em_fire && em_cnt_reg == bda_pkg::cnt_t'(1)) begin
            em_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (em_load) begin
            em_bcd_reg <= al_bcd_reg;
            em_cnt_reg <= al_ndig_reg;
        end else if (em_fire) begin
            em_bcd_reg <= {em_bcd_reg[bda_pkg::BcdW-5:0], 4'd0};
            em_cnt_reg <= em_cnt_reg - bda_pkg::cnt_t'(1);
        end
    end

    assign m_valid      = em_valid_reg;
    assign m_digit_char = {bda_pkg::AsciiDigitHi, em_bcd_reg[bda_pkg::BcdW-1 -: 4]};
    assign m_last_digit = (em_cnt_reg == bda_pkg::cnt_t'(1));

    `BDA_ASSERT_IMP(a_cnt_range, em_valid_reg, (em_cnt_reg != 4'd0) && (em_cnt_reg <= 4'd10))
    `BDA_ASSERT_IMP(a_digit_range, m_valid, m_digit_char[3:0] <= 4'd9)
    `BDA_ASSERT_NXT(a_no_lead_zero, em_load, (m_digit_char[3:0] != 4'd0) || m_last_digit)
    `BDA_ASSERT_IMP(a_ready_empty, !stg_valid_reg[0], s_ready)

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binary to decimal ASCII unit testbench
// Drives 32-bit values with random gaps and back-pressure, expands each taken
// request into its expected decimal digit stream and checks every digit beat.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          ClkHalf     = 5;
    localparam int          ResetCycles = 7;
    localparam int          HangLimit   = 1000;
    localparam int          DrainCycles = 20;
    localparam int          RandomCount = 245;
    localparam int          PrintCap    = 40;
    localparam logic [5:0]  AsciiZero   = 6'd48;

    typedef struct packed {
        logic [bda_pkg::CharW-1:0] digit_char;
        logic                      last_digit;
    } digit_beat_t;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_valid  = 1'b0;
    logic                      s_ready;
    logic [bda_pkg::NumW-1:0]  s_number = '0;
    logic                      m_valid;
    logic                      m_ready  = 1'b0;
    logic [bda_pkg::CharW-1:0] m_digit_char;
    logic                      m_last_digit;

    logic [bda_pkg::NumW-1:0]  number_queue[$];
    digit_beat_t               pending_digits[$];
    logic                      s_fire_q   = 1'b0;
    logic                      burst_mode = 1'b0;
    int unsigned               gap_left   = 0;
    int unsigned               stall_left = 0;
    int unsigned               error_count = 0;
    int unsigned               values_taken = 0;
    int unsigned               digits_checked = 0;
    int unsigned               ten_digit_values = 0;
    int unsigned               zero_values = 0;

    binary_to_decimal_ascii_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_number     (s_number),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit)
    );

    initial begin
        forever #ClkHalf aclk = ~aclk;
    end

    // Alternate stretches of free-running traffic with stretches of random idle gaps.
    initial begin
        forever begin
            repeat ($urandom_range(400, 100)) @(posedge aclk);
            burst_mode = ~burst_mode;
        end
    end

    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (burst_mode) begin
            return 0;
        end
        if (roll < 60) begin
            return $urandom_range(2, 1);
        end
        if (roll < 90) begin
            return $urandom_range(8, 3);
        end
        return $urandom_range(60, 20);
    endfunction

    // Push the digit beats a value turns into, most significant first.
    function automatic void expand_decimal(input logic [bda_pkg::NumW-1:0] value);
        logic [bda_pkg::NumW-1:0] rest;
        logic [3:0]               rev[bda_pkg::NumDigits];
        int                       count;
        digit_beat_t              beat;
        rest  = value;
        count = 0;
        do begin
            rev[count] = 4'(rest % 10);
            rest       = rest / 10;
            count++;
        end while (rest != 0);
        for (int k = count - 1; k >= 0; k--) begin
            beat.digit_char = AsciiZero + 6'(rev[k]);
            beat.last_digit = (k == 0);
            pending_digits.push_back(beat);
        end
        if (count == bda_pkg::NumDigits) begin
            ten_digit_values++;
        end
        if (value == 0) begin
            zero_values++;
        end
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PrintCap) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    // Request driver: hold the payload until taken, then idle or advance.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!s_valid || s_fire_q) begin
            if (gap_left != 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (number_queue.size() != 0) begin
                s_valid  <= 1'b1;
                s_number <= number_queue.pop_front();
                gap_left <= ($urandom_range(99, 0) < 40) ? 0 : idle_length();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Digit receiver back-pressure.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(99, 0) < 25) begin
                stall_left <= idle_length();
            end
        end
    end

    // Monitor: expand taken requests, compare digit beats in order.
    always @(posedge aclk) begin
        digit_beat_t want;
        if (!aresetn) begin
            s_fire_q <= 1'b0;
        end else begin
            s_fire_q <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                expand_decimal(s_number);
                values_taken++;
            end
            if (m_valid && m_ready) begin
                digits_checked++;
                if (pending_digits.size() == 0) begin
                    report_mismatch($sformatf("unexpected digit char %0d last %0b",
                                              m_digit_char, m_last_digit));
                end else begin
                    want = pending_digits.pop_front();
                    if (m_digit_char !== want.digit_char) begin
                        report_mismatch($sformatf("digit_char %0d, wanted %0d",
                                                  m_digit_char, want.digit_char));
                    end
                    if (m_last_digit !== want.last_digit) begin
                        report_mismatch($sformatf("last_digit %0b, wanted %0b",
                                                  m_last_digit, want.last_digit));
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no handshake happens for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < HangLimit) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no handshake for %0d cycles", HangLimit);
        $display("binary_to_decimal_ascii_unit verification failed");
        $finish;
    end

    initial begin
        longint unsigned lo;
        longint unsigned hi;
        int unsigned     ndig;
        int unsigned     roll;

        // Zero, digit-count boundaries, extremes and alternating bit patterns.
        number_queue = '{32'd0, 32'd1, 32'd5, 32'd9, 32'd10, 32'd19, 32'd99,
                         32'd100, 32'd1000, 32'd9999, 32'd10000, 32'd99999,
                         32'd100000, 32'd999999, 32'd1000000, 32'd9999999,
                         32'd10000000, 32'd99999999, 32'd100000000,
                         32'd999999999, 32'd1000000000, 32'hFFFF_FFFF,
                         32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555};

        for (int i = 0; i < RandomCount; i++) begin
            roll = $urandom_range(99, 0);
            ndig = $urandom_range(bda_pkg::NumDigits, 1);
            lo   = 1;
            for (int k = 1; k < ndig; k++) begin
                lo = lo * 10;
            end
            hi = (ndig == bda_pkg::NumDigits) ? 64'hFFFF_FFFF : lo * 10 - 1;
            if (roll < 60) begin
                number_queue.push_back($urandom_range(int'(hi), int'(lo)));
            end else if (roll < 85) begin
                number_queue.push_back($urandom);
            end else if (roll < 95) begin
                number_queue.push_back($urandom_range(20, 0));
            end else if (roll < 98) begin
                number_queue.push_back(32'(lo));
            end else begin
                number_queue.push_back(32'(lo - 1));
            end
        end

        repeat (ResetCycles) @(negedge aclk);
        aresetn <= 1'b1;

        while (number_queue.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (pending_digits.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DrainCycles) @(posedge aclk);

        $display("Converted %0d values into %0d checked digits (%0d zero, %0d ten-digit).",
                 values_taken, digits_checked, zero_values, ten_digit_values);
        $display("Idle gaps and output stalls ran in both bursty and free-running stretches.");
        if (error_count == 0) begin
            $display("binary_to_decimal_ascii_unit verification clean");
        end else begin
            $display("%0d mismatches found", error_count);
            $display("binary_to_decimal_ascii_unit verification failed");
        end
        $finish;
    end

endmodule
